// ===== sv/mrs_pkg.sv =====
package mrs_pkg;

  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 10;
  localparam int COORD_BITS = 24;
  localparam int CNT_BITS   = 21;
  localparam int SUM_BITS   = 44;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int STEP_BITS  = $clog2(COORD_BITS);
  localparam int IN_BITS    = 96;
  localparam int OUT_BITS   = 160;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic        [CNT_BITS-1:0]   cnt_t;
  typedef logic        [COL_BITS-1:0]   col_t;
  typedef logic        [ROW_BITS-1:0]   row_t;

  localparam logic [COL_BITS:0] COL_LIMIT = (COL_BITS + 1)'(MAX_COLS);
  localparam logic [ROW_BITS:0] ROW_LIMIT = (ROW_BITS + 1)'(MAX_ROWS);
  localparam cnt_t POINT_CAP = CNT_BITS'(MAX_COLS * MAX_ROWS);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

endpackage

// ===== sv/masked_region_statistics.sv =====
// Pixels that do not close a frame are taken one per cycle and folded into the
// running statistics in that same cycle.
// The last pixel of a frame starts three divisions, one after another, on the one
// shared bit-serial divider; the output register is then loaded once it is free.
// No pixel is taken meanwhile.
// Synchronous active-high reset clears all statistics and drops any result.
module masked_region_statistics (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_col[9:0], pixel_row[19:10], point_x[43:20], point_y[67:44],
  // point_z[91:68], zero fill[95:92]
  input  logic [mrs_pkg::IN_BITS-1:0]   s_axis_tdata,
  // pixel_valid
  input  logic                          s_axis_tuser,
  // frame_last
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // centroid_x[23:0], centroid_y[47:24], centroid_z[71:48],
  // object_height[95:72], box_left[105:96], box_top[115:106],
  // box_width[126:116], box_height[137:127], point_count[158:138],
  // zero fill[159]
  output logic [mrs_pkg::OUT_BITS-1:0]  m_axis_tdata,
  // region_empty
  output logic                          m_axis_tuser
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_WRAP = 2'd2;

  logic [1:0] state;
  logic [1:0] sel;
  logic       kick;

  // running statistics
  mrs_pkg::sum_t   sum_x;
  mrs_pkg::sum_t   sum_y;
  mrs_pkg::sum_t   sum_z;
  mrs_pkg::cnt_t   masked_count;
  mrs_pkg::coord_t low_z;
  mrs_pkg::coord_t high_z;
  mrs_pkg::col_t   low_col;
  mrs_pkg::col_t   high_col;
  mrs_pkg::row_t   low_row;
  mrs_pkg::row_t   high_row;

  // quotients held until the result is loaded
  mrs_pkg::coord_t mean_x;
  mrs_pkg::coord_t mean_y;

  // unpack the incoming item
  mrs_pkg::col_t   pixel_col;
  mrs_pkg::row_t   pixel_row;
  mrs_pkg::coord_t point_x;
  mrs_pkg::coord_t point_y;
  mrs_pkg::coord_t point_z;

  assign pixel_col = s_axis_tdata[9:0];
  assign pixel_row = s_axis_tdata[19:10];
  assign point_x   = s_axis_tdata[43:20];
  assign point_y   = s_axis_tdata[67:44];
  assign point_z   = s_axis_tdata[91:68];

  logic take;
  logic hit;

  assign s_axis_tready = (state == S_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;

  // count the pixel only when masked, inside the raster and below the cap
  assign hit = take && s_axis_tuser
             && ({1'b0, pixel_col} < mrs_pkg::COL_LIMIT)
             && ({1'b0, pixel_row} < mrs_pkg::ROW_LIMIT)
             && (masked_count < mrs_pkg::POINT_CAP);

  // shared divider, steered to one sum at a time
  mrs_pkg::sum_t   div_num;
  logic            div_done;
  mrs_pkg::coord_t div_q;

  always_comb begin
    case (sel)
      2'd0:    div_num = sum_x;
      2'd1:    div_num = sum_y;
      default: div_num = sum_z;
    endcase
  end

  mrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (kick),
    .dividend (div_num),
    .divisor  (masked_count),
    .done     (div_done),
    .quotient (div_q)
  );

  logic out_free;
  logic load;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign load     = (state == S_WRAP) && out_free;

  // sequencer: accumulate in idle, run the three divisions, then load
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 2'd0;
      kick  <= 1'b0;
    end else begin
      kick <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take && s_axis_tlast) begin
            state <= S_DIV;
            sel   <= 2'd0;
            kick  <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sel == 2'd2) begin
              state <= S_WRAP;
            end else begin
              sel  <= sel + 2'd1;
              kick <= 1'b1;
            end
          end
        end
        S_WRAP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // capture the first two means; the third is held in its own register below
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      if (sel == 2'd0) begin
        mean_x <= div_q;
      end
      if (sel == 2'd1) begin
        mean_y <= div_q;
      end
    end
  end

  mrs_pkg::coord_t mean_z;

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done && sel == 2'd2) begin
      mean_z <= div_q;
    end
  end

  // statistics: fold masked pixels in, clear once the result is loaded
  always_ff @(posedge clk) begin
    if (rst || load) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      masked_count <= '0;
      low_z        <= mrs_pkg::COORD_MAX;
      high_z       <= mrs_pkg::COORD_MIN;
      low_col      <= '1;
      high_col     <= '0;
      low_row      <= '1;
      high_row     <= '0;
    end else if (hit) begin
      sum_x        <= sum_x + mrs_pkg::sum_t'(point_x);
      sum_y        <= sum_y + mrs_pkg::sum_t'(point_y);
      sum_z        <= sum_z + mrs_pkg::sum_t'(point_z);
      masked_count <= masked_count + 1'b1;
      if (point_z < low_z) begin
        low_z <= point_z;
      end
      if (point_z > high_z) begin
        high_z <= point_z;
      end
      if (pixel_col < low_col) begin
        low_col <= pixel_col;
      end
      if (pixel_col > high_col) begin
        high_col <= pixel_col;
      end
      if (pixel_row < low_row) begin
        low_row <= pixel_row;
      end
      if (pixel_row > high_row) begin
        high_row <= pixel_row;
      end
    end
  end

  // assemble the result; an empty frame gives zeros and the empty flag
  logic                          empty;
  logic [mrs_pkg::OUT_BITS-1:0]  result;
  logic [mrs_pkg::COORD_BITS-1:0] z_span;
  logic [mrs_pkg::COL_BITS:0]    col_span;
  logic [mrs_pkg::ROW_BITS:0]    row_span;

  assign empty    = (masked_count == '0);
  assign z_span   = high_z - low_z;
  assign col_span = {1'b0, high_col} - {1'b0, low_col} + 1'b1;
  assign row_span = {1'b0, high_row} - {1'b0, low_row} + 1'b1;

  always_comb begin
    if (empty) begin
      result = '0;
    end else begin
      result = {1'b0, masked_count, row_span, col_span, low_row, low_col,
                z_span, mean_z, mean_y, mean_x};
    end
  end

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= result;
      m_axis_tuser <= empty;
    end
  end

endmodule

// ===== sv/mrs_div.sv =====
// Signed sum divided by an unsigned count, one quotient bit a cycle,
// truncated toward zero. The quotient magnitude is known to fit the
// coordinate width, so only that many steps are run.
module mrs_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mrs_pkg::sum_t     dividend,
  input  mrs_pkg::cnt_t     divisor,
  output logic              done,
  output mrs_pkg::coord_t   quotient
);

  logic                                   busy;
  logic [mrs_pkg::STEP_BITS-1:0]          step;
  mrs_pkg::cnt_t                          rem;
  logic [mrs_pkg::COORD_BITS-1:0]         shreg;
  logic                                   neg;
  logic [mrs_pkg::SUM_BITS-1:0]           mag;
  logic [mrs_pkg::CNT_BITS:0]             trial;
  logic                                   fits;

  assign mag   = dividend[mrs_pkg::SUM_BITS-1] ? -dividend : dividend;
  assign trial = {rem, shreg[mrs_pkg::COORD_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          step <= '0;
        end
      end else begin
        step <= step + 1'b1;
        if (step == mrs_pkg::STEP_BITS'(mrs_pkg::COORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      neg   <= dividend[mrs_pkg::SUM_BITS-1];
      rem   <= mrs_pkg::CNT_BITS'(mag[mrs_pkg::SUM_BITS-1:mrs_pkg::COORD_BITS]);
      shreg <= mag[mrs_pkg::COORD_BITS-1:0];
    end else if (busy) begin
      // subtract the divisor where it fits and shift the quotient bit in
      if (fits) begin
        rem <= mrs_pkg::CNT_BITS'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[mrs_pkg::CNT_BITS-1:0];
      end
      shreg <= {shreg[mrs_pkg::COORD_BITS-2:0], fits};
    end
  end

  assign quotient = neg ? -mrs_pkg::coord_t'(shreg) : mrs_pkg::coord_t'(shreg);

endmodule

// ===== tb/tb_masked_region_statistics.sv =====
module tb_masked_region_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PIXELS = 1600;
  localparam int RASTER_POINTS = mrs_pkg::MAX_COLS * mrs_pkg::MAX_ROWS;

  // One pixel as the camera stream presents it.
  typedef struct {
    bit              valid;
    mrs_pkg::col_t   col;
    mrs_pkg::row_t   row;
    mrs_pkg::coord_t x;
    mrs_pkg::coord_t y;
    mrs_pkg::coord_t z;
    bit              last;
  } pixel_t;

  // Result tdata layout, highest field first so it can be cast from the bus.
  typedef struct packed {
    logic             pad;
    mrs_pkg::cnt_t    count;
    logic [10:0]      bheight;
    logic [10:0]      bwidth;
    mrs_pkg::row_t    top;
    mrs_pkg::col_t    left;
    logic [23:0]      oheight;
    mrs_pkg::coord_t  cz;
    mrs_pkg::coord_t  cy;
    mrs_pkg::coord_t  cx;
  } region_t;

  typedef struct {
    region_t r;
    bit      empty;
  } region_out_t;

  typedef struct {
    pixel_t      pix;
    bit          typed;
    region_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mrs_pkg::IN_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mrs_pkg::OUT_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;

  masked_region_statistics dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // Running statistics of the frame in progress, as the block should hold them.
  longint          acc_x, acc_y, acc_z;
  int unsigned     pts;
  mrs_pkg::coord_t z_lo, z_hi;
  mrs_pkg::col_t   col_lo, col_hi;
  mrs_pkg::row_t   row_lo, row_hi;

  region_out_t pending_regions[$];
  stim_row_t   stim_table[$];
  bit          quiet_phase = 1'b0;
  int          mismatch_count = 0;
  int          pixels_sent = 0;
  int          frames_sent = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;

  string field_names[10] = '{"centroid_x", "centroid_y", "centroid_z", "object_height",
                             "box_left", "box_top", "box_width", "box_height",
                             "point_count", "region_empty"};

  task automatic clear_stats();
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    pts = 0;
    z_lo = mrs_pkg::COORD_MAX;
    z_hi = mrs_pkg::COORD_MIN;
    col_lo = '1;
    col_hi = '0;
    row_lo = '1;
    row_hi = '0;
  endtask

  // Fold one accepted pixel into the statistics; on the frame's last pixel
  // form the region result and start afresh.
  task automatic fold_pixel(input pixel_t p, output bit done, output region_out_t res);
    longint n;
    done = 1'b0;
    res.r = '0;
    res.empty = 1'b0;
    // Drop pixels off the raster and any beyond the point cap.
    if (p.valid && int'(p.col) < mrs_pkg::MAX_COLS && int'(p.row) < mrs_pkg::MAX_ROWS &&
        pts < RASTER_POINTS) begin
      acc_x += longint'(p.x);
      acc_y += longint'(p.y);
      acc_z += longint'(p.z);
      pts++;
      if (p.z < z_lo) z_lo = p.z;
      if (p.z > z_hi) z_hi = p.z;
      if (p.col < col_lo) col_lo = p.col;
      if (p.col > col_hi) col_hi = p.col;
      if (p.row < row_lo) row_lo = p.row;
      if (p.row > row_hi) row_hi = p.row;
    end
    if (p.last) begin
      done = 1'b1;
      if (pts == 0) begin
        res.empty = 1'b1;
      end else begin
        n = pts;
        // SystemVerilog division truncates toward zero, as the centroid needs.
        res.r.cx = mrs_pkg::coord_t'(acc_x / n);
        res.r.cy = mrs_pkg::coord_t'(acc_y / n);
        res.r.cz = mrs_pkg::coord_t'(acc_z / n);
        res.r.oheight = 24'(z_hi - z_lo);
        res.r.left = col_lo;
        res.r.top = row_lo;
        res.r.bwidth = 11'(col_hi - col_lo + 1);
        res.r.bheight = 11'(row_hi - row_lo + 1);
        res.r.count = mrs_pkg::cnt_t'(pts);
      end
      clear_stats();
    end
  endtask

  function automatic logic [63:0] region_field(region_t r, bit e, int k);
    case (k)
      0: return {40'b0, r.cx};
      1: return {40'b0, r.cy};
      2: return {40'b0, r.cz};
      3: return {40'b0, r.oheight};
      4: return {54'b0, r.left};
      5: return {54'b0, r.top};
      6: return {53'b0, r.bwidth};
      7: return {53'b0, r.bheight};
      8: return {43'b0, r.count};
      default: return {63'b0, e};
    endcase
  endfunction

  function automatic region_t mk_region(int cx, int cy, int cz, int oh, int left, int top,
                                        int w, int h, int n);
    region_t r;
    r = '0;
    r.cx = mrs_pkg::coord_t'(cx);
    r.cy = mrs_pkg::coord_t'(cy);
    r.cz = mrs_pkg::coord_t'(cz);
    r.oheight = 24'(oh);
    r.left = mrs_pkg::col_t'(left);
    r.top = mrs_pkg::row_t'(top);
    r.bwidth = 11'(w);
    r.bheight = 11'(h);
    r.count = mrs_pkg::cnt_t'(n);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none while things are quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic mrs_pkg::coord_t pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return mrs_pkg::COORD_MAX;
    if (r < 20) return mrs_pkg::COORD_MIN;
    if (r < 35) return mrs_pkg::coord_t'($urandom_range(0, 200) - 100);
    return mrs_pkg::coord_t'($urandom());
  endfunction

  task automatic add_row(bit v, int c, int r, int x, int y, int z, bit l,
                         bit typed = 1'b0, region_t res = '0, bit empty = 1'b0);
    stim_row_t s;
    s.pix.valid = v;
    s.pix.col = mrs_pkg::col_t'(c);
    s.pix.row = mrs_pkg::row_t'(r);
    s.pix.x = mrs_pkg::coord_t'(x);
    s.pix.y = mrs_pkg::coord_t'(y);
    s.pix.z = mrs_pkg::coord_t'(z);
    s.pix.last = l;
    s.typed = typed;
    s.want.r = res;
    s.want.empty = empty;
    stim_table = {stim_table, s};
  endtask

  // Present one pixel after an optional gap, hold it until taken, then fold it
  // into the statistics. The typed expectation replaces the computed one.
  task automatic send_pixel(pixel_t p, bit typed = 1'b0, region_out_t fixed = '{default: 0});
    int gap;
    bit done;
    region_out_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.valid;
    s_axis_tlast <= p.last;
    s_axis_tdata <= {4'b0, p.z, p.y, p.x, p.row, p.col};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    pixels_sent++;
    fold_pixel(p, done, res);
    if (done) begin
      frames_sent++;
      pending_regions = {pending_regions, (typed ? fixed : res)};
    end
  endtask

  task automatic check_region(logic [mrs_pkg::OUT_BITS-1:0] data, logic empty);
    region_out_t want;
    region_t got;
    logic [63:0] w, g;
    got = region_t'(data);
    results_seen++;
    if (pending_regions.size() == 0) begin
      $error("region result arrived with nothing expected");
      mismatch_count++;
      return;
    end
    want = pending_regions.pop_front();
    for (int k = 0; k < 10; k++) begin
      w = region_field(want.r, want.empty, k);
      g = region_field(got, empty, k);
      if (w !== g) begin
        $error("%s: expected %0h, actual %0h", field_names[k], w, g);
        mismatch_count++;
      end
    end
  endtask

  // Receiver: stall for random stretches, or not at all while quiet.
  always @(negedge clk) begin
    if (stall_left == 0 && !quiet_phase && $urandom_range(0, 99) < 25)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      check_region(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_regions.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int len, w, c0, r0, density, r;
    bit scatter;
    pixel_t p;

    clear_stats();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed table: empty frame straight after reset.
    add_row(0, 3, 4, 100, -100, 5, 1, 1, '0, 1);
    // Single masked pixel that closes its frame, extreme x and y.
    add_row(1, 0, 0, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, 0, 1, 1,
            mk_region(mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, 0, 0, 0, 0, 1, 1, 1));
    // Opposite corners and full z range: widest box, tallest object.
    add_row(1, 1023, 1023, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, mrs_pkg::COORD_MIN, 0);
    add_row(1, 0, 0, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, mrs_pkg::COORD_MAX, 1, 1,
            mk_region(mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, 0, 24'hFFFFFF, 0, 0,
                      1024, 1024, 2));
    // Unmasked last pixel must not touch the statistics.
    add_row(1, 5, 7, -3, 3, 10, 0);
    add_row(1, 6, 7, -2, -4, 10, 0);
    add_row(0, 900, 800, mrs_pkg::COORD_MIN, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MIN, 1);
    // Equal z everywhere: the first point sets both bounds.
    add_row(1, 10, 2, -65536, 65536, -20000, 0);
    add_row(1, 11, 2, -65536, 65536, -20000, 0);
    add_row(1, 12, 2, -65536, 65536, -20000, 1);
    // Negative means truncate toward zero.
    add_row(1, 20, 30, -5, 5, -7, 0);
    add_row(1, 21, 30, 0, 0, 0, 1);
    // Several unmasked pixels with extreme content still give an empty region.
    add_row(0, 1023, 1023, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MAX, mrs_pkg::COORD_MAX, 0);
    add_row(0, 0, 0, mrs_pkg::COORD_MIN, mrs_pkg::COORD_MIN, mrs_pkg::COORD_MIN, 0);
    add_row(0, 512, 512, 0, 0, 0, 1, 1, '0, 1);
    // All-ones and single-bit coordinates.
    add_row(1, 1023, 0, -1, -1, -1, 0);
    add_row(1, 0, 1023, 1, 1, 1, 1);

    foreach (stim_table[i])
      send_pixel(stim_table[i].pix, stim_table[i].typed, stim_table[i].want);

    // Random frames: mostly small raster windows scanned row-major, some
    // scattered pixels, varied mask density including empty and full masks.
    while (pixels_sent < RANDOM_PIXELS + stim_table.size()) begin
      quiet_phase = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 300);
      r = $urandom_range(0, 99);
      if (r < 10) density = 0;
      else if (r < 20) density = 100;
      else density = $urandom_range(1, 99);
      w = $urandom_range(1, 32);
      c0 = $urandom_range(0, 1023);
      r0 = $urandom_range(0, 1023);
      scatter = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        p.valid = ($urandom_range(1, 100) <= density);
        p.col = scatter ? mrs_pkg::col_t'($urandom()) : mrs_pkg::col_t'(c0 + i % w);
        p.row = scatter ? mrs_pkg::row_t'($urandom()) : mrs_pkg::row_t'(r0 + i / w);
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
        p.last = (i == len - 1);
        send_pixel(p);
      end
    end
    quiet_phase = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    // Let any stray result show up before calling it done.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels in %0d frames sent, %0d region results checked, %0d mismatches",
             pixels_sent, frames_sent, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== masked_region_statistics.f =====
sv/mrs_pkg.sv
sv/mrs_div.sv
sv/masked_region_statistics.sv
tb/tb_masked_region_statistics.sv
